// ----- src/aps_pkg.sv -----
// shared types and constants for the amplifier power sequencer with brownout guard
// no dependencies; used by aps_step and amp_power_sequencer_brownout
package aps_pkg;

  // sequencer state codes
  localparam logic [1:0] ST_HOLD = 2'd0;
  localparam logic [1:0] ST_MUTE = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_DOWN = 2'd3;

  // command codes
  localparam logic CMD_POLL    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_RESET_WAIT = 2'd0;
  localparam logic [1:0] CFG_MUTE_WAIT  = 2'd1;
  localparam logic [1:0] CFG_DROP_LIMIT = 2'd2;

  // widths and reset values
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0]   RESET_WAIT_DEFAULT = 16'd300;
  localparam logic [TICK_W-1:0]   MUTE_WAIT_DEFAULT  = 16'd500;
  localparam logic [SAMPLE_W-1:0] DROP_LIMIT_DEFAULT = 10'd10;

  // persistent sequencer state
  typedef struct packed {
    logic [1:0]          seq_state;
    logic [TICK_W-1:0]   start_time;
    logic [SAMPLE_W-1:0] peak_sample;
    logic [1:0]          last_tick_top;
    logic                mute_out;
    logic                release_out;
  } seq_t;

  // configuration settings
  typedef struct packed {
    logic [TICK_W-1:0]   reset_wait;
    logic [TICK_W-1:0]   mute_wait;
    logic [SAMPLE_W-1:0] drop_limit;
  } cfg_t;

endpackage

// ----- src/aps_step.sv -----
// next-state logic for one command of the power sequencer
// depends on aps_pkg for state codes and the state and config structs
module aps_step (
  input  aps_pkg::seq_t                      state_i,
  input  aps_pkg::cfg_t                      cfg_i,
  input  logic                               cmd_i,
  input  logic [aps_pkg::TICK_W-1:0]         now_ticks_i,
  input  logic [aps_pkg::SAMPLE_W-1:0]       adc_sample_i,
  input  logic                               button_i,
  output aps_pkg::seq_t                      state_o,
  output logic                               flash_o
);

  logic [aps_pkg::TICK_W-1:0]   elapsed;
  logic [1:0]                   top;
  logic [aps_pkg::SAMPLE_W-1:0] peak_decay;
  logic [aps_pkg::SAMPLE_W-1:0] peak_track;
  logic [aps_pkg::SAMPLE_W-1:0] drop;

  assign elapsed = now_ticks_i - state_i.start_time;
  assign top     = now_ticks_i[aps_pkg::TICK_W-1 -: 2];

  // decay the peak by one when the top tick bits change
  assign peak_decay = ((top != state_i.last_tick_top) && (state_i.peak_sample != '0))
                      ? state_i.peak_sample - 1'b1 : state_i.peak_sample;

  // peak follows rising samples while running
  assign peak_track = (peak_decay < adc_sample_i) ? adc_sample_i : peak_decay;
  assign drop       = peak_track - adc_sample_i;

  always_comb begin
    state_o = state_i;
    flash_o = 1'b0;
    if (cmd_i == aps_pkg::CMD_RESTART) begin
      state_o.seq_state   = aps_pkg::ST_HOLD;
      state_o.start_time  = now_ticks_i;
      state_o.mute_out    = 1'b1;
      state_o.release_out = 1'b0;
    end else begin
      // power-up sequence, both waits measured from sequence start
      if ((state_o.seq_state == aps_pkg::ST_HOLD) && (elapsed >= cfg_i.reset_wait)) begin
        state_o.release_out = 1'b1;
        state_o.seq_state   = aps_pkg::ST_MUTE;
      end
      if ((state_o.seq_state == aps_pkg::ST_MUTE) && (elapsed >= cfg_i.mute_wait)) begin
        state_o.mute_out  = 1'b0;
        state_o.seq_state = aps_pkg::ST_RUN;
      end
      state_o.peak_sample = peak_decay;
      // brownout check, or restart from down on a button press
      if (state_o.seq_state == aps_pkg::ST_RUN) begin
        state_o.peak_sample = peak_track;
        if (drop > cfg_i.drop_limit) begin
          state_o.mute_out    = 1'b1;
          state_o.release_out = 1'b0;
          state_o.seq_state   = aps_pkg::ST_DOWN;
          flash_o             = 1'b1;
        end
      end else if ((state_o.seq_state == aps_pkg::ST_DOWN) && button_i) begin
        state_o.seq_state   = aps_pkg::ST_HOLD;
        state_o.start_time  = now_ticks_i;
        state_o.mute_out    = 1'b1;
        state_o.release_out = 1'b0;
        state_o.peak_sample = adc_sample_i;
      end
      state_o.last_tick_top = top;
    end
  end

endmodule

// ----- src/amp_power_sequencer_brownout.sv -----
// the result is registered at the input transfer and appears on the output in the next cycle
// throughput: one command per cycle; the input stalls only while a result waits unread
// the sequencer state updates at the input transfer, so the next command sees it at once
// reset: sequencer in reset state, muted and held in reset, peak 0, config at defaults,
// output register empty
// depends on aps_pkg and aps_step
module amp_power_sequencer_brownout (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [aps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [aps_pkg::CFG_W-1:0]          cfg_data_i,
  // command channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [aps_pkg::TICK_W-1:0]         now_ticks_i,
  input  logic [aps_pkg::SAMPLE_W-1:0]       adc_sample_i,
  input  logic                               button_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               mute_level_o,
  output logic                               reset_release_o,
  output logic [1:0]                         amp_state_o,
  output logic                               flash_start_o,
  output logic [aps_pkg::SAMPLE_W-1:0]       peak_level_o
);

  aps_pkg::seq_t state_q, state_d;
  aps_pkg::cfg_t cfg_q;
  logic          flash_d;
  logic          out_valid_q;
  logic          flash_q;
  logic          in_xfer;

  // input is taken whenever the output register is empty or draining
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  aps_step u_step (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd_i),
    .now_ticks_i  (now_ticks_i),
    .adc_sample_i (adc_sample_i),
    .button_i     (button_i),
    .state_o      (state_d),
    .flash_o      (flash_d)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_wait <= aps_pkg::RESET_WAIT_DEFAULT;
      cfg_q.mute_wait  <= aps_pkg::MUTE_WAIT_DEFAULT;
      cfg_q.drop_limit <= aps_pkg::DROP_LIMIT_DEFAULT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        aps_pkg::CFG_RESET_WAIT: cfg_q.reset_wait <= cfg_data_i;
        aps_pkg::CFG_MUTE_WAIT:  cfg_q.mute_wait  <= cfg_data_i;
        aps_pkg::CFG_DROP_LIMIT: cfg_q.drop_limit <= cfg_data_i[aps_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.seq_state     <= aps_pkg::ST_HOLD;
      state_q.start_time    <= '0;
      state_q.peak_sample   <= '0;
      state_q.last_tick_top <= '0;
      state_q.mute_out      <= 1'b1;
      state_q.release_out   <= 1'b0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // flash pulse payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_q <= 1'b0;
    end else if (in_xfer) begin
      flash_q <= flash_d;
    end
  end

  // results read straight from the updated state
  assign out_valid_o     = out_valid_q;
  assign mute_level_o    = state_q.mute_out;
  assign reset_release_o = state_q.release_out;
  assign amp_state_o     = state_q.seq_state;
  assign flash_start_o   = flash_q;
  assign peak_level_o    = state_q.peak_sample;

endmodule

// ----- tb/sv/aps_status_board.sv -----
`timescale 1ns / 1ps
// scoreboard for the amplifier power sequencer: tracks sequencer state and checks results
// depends on aps_pkg for state codes, command codes and register indexes
package aps_tb_pkg;

  // one result as seen on the output channel
  typedef struct packed {
    logic                         mute_level;
    logic                         reset_release;
    logic [1:0]                   amp_state;
    logic                         flash_start;
    logic [aps_pkg::SAMPLE_W-1:0] peak_level;
  } amp_status_t;

  class amp_status_board;
    aps_pkg::seq_t seq;
    aps_pkg::cfg_t cfg;
    amp_status_t   pending_status[$];
    int            mismatches;

    function new();
      seq.seq_state     = aps_pkg::ST_HOLD;
      seq.start_time    = '0;
      seq.peak_sample   = '0;
      seq.last_tick_top = '0;
      seq.mute_out      = 1'b1;
      seq.release_out   = 1'b0;
      cfg.reset_wait    = aps_pkg::RESET_WAIT_DEFAULT;
      cfg.mute_wait     = aps_pkg::MUTE_WAIT_DEFAULT;
      cfg.drop_limit    = aps_pkg::DROP_LIMIT_DEFAULT;
      mismatches        = 0;
    endfunction

    function void write_register(logic [aps_pkg::CFG_IDX_W-1:0] idx,
                                 logic [aps_pkg::CFG_W-1:0] data);
      case (idx)
        aps_pkg::CFG_RESET_WAIT: cfg.reset_wait = data;
        aps_pkg::CFG_MUTE_WAIT:  cfg.mute_wait  = data;
        aps_pkg::CFG_DROP_LIMIT: cfg.drop_limit = data[aps_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    endfunction

    // power-up sequence starts over: held in reset and muted
    function void restart_sequence(logic [aps_pkg::TICK_W-1:0] now);
      seq.seq_state   = aps_pkg::ST_HOLD;
      seq.start_time  = now;
      seq.mute_out    = 1'b1;
      seq.release_out = 1'b0;
    endfunction

    // advance the sequencer by one accepted command and queue the status it produces
    function void note_command(logic cmd, logic [aps_pkg::TICK_W-1:0] now,
                               logic [aps_pkg::SAMPLE_W-1:0] sample, logic button);
      logic [aps_pkg::TICK_W-1:0]   elapsed;
      logic [1:0]                   top;
      logic [aps_pkg::SAMPLE_W-1:0] drop;
      amp_status_t                  status;
      status.flash_start = 1'b0;
      if (cmd == aps_pkg::CMD_RESTART) begin
        restart_sequence(now);
      end else begin
        // waits count from sequence start, modulo the tick width
        elapsed = now - seq.start_time;
        if (seq.seq_state == aps_pkg::ST_HOLD && elapsed >= cfg.reset_wait) begin
          seq.release_out = 1'b1;
          seq.seq_state   = aps_pkg::ST_MUTE;
        end
        if (seq.seq_state == aps_pkg::ST_MUTE && elapsed >= cfg.mute_wait) begin
          seq.mute_out  = 1'b0;
          seq.seq_state = aps_pkg::ST_RUN;
        end
        // peak decays when the top tick bits move, floor at zero
        top = now[aps_pkg::TICK_W-1 -: 2];
        if (top != seq.last_tick_top && seq.peak_sample != '0)
          seq.peak_sample = seq.peak_sample - 1'b1;
        if (seq.seq_state == aps_pkg::ST_RUN) begin
          if (seq.peak_sample < sample)
            seq.peak_sample = sample;
          drop = seq.peak_sample - sample;
          if (drop > cfg.drop_limit) begin
            seq.mute_out       = 1'b1;
            seq.release_out    = 1'b0;
            seq.seq_state      = aps_pkg::ST_DOWN;
            status.flash_start = 1'b1;
          end
        end else if (seq.seq_state == aps_pkg::ST_DOWN && button) begin
          restart_sequence(now);
          seq.peak_sample = sample;
        end
        seq.last_tick_top = top;
      end
      status.mute_level    = seq.mute_out;
      status.reset_release = seq.release_out;
      status.amp_state     = seq.seq_state;
      status.peak_level    = seq.peak_sample;
      pending_status.push_back(status);
    endfunction

    function void report(string field, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
      end
    endfunction

    // compare one result transfer against the oldest queued status
    function void check_status(amp_status_t got);
      amp_status_t want;
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
      end else begin
        want = pending_status.pop_front();
        report("mute_level", 32'(want.mute_level), 32'(got.mute_level));
        report("reset_release", 32'(want.reset_release), 32'(got.reset_release));
        report("amp_state", 32'(want.amp_state), 32'(got.amp_state));
        report("flash_start", 32'(want.flash_start), 32'(got.flash_start));
        report("peak_level", 32'(want.peak_level), 32'(got.peak_level));
      end
    endfunction

    function int pending_count();
      return pending_status.size();
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_amp_power_sequencer_brownout.sv -----
`timescale 1ns / 1ps
// testbench top for amp_power_sequencer_brownout: directed and random command streams
// depends on aps_pkg, aps_tb_pkg (scoreboard) and the sequencer rtl
module tb_amp_power_sequencer_brownout;

  localparam int CYCLE_LIMIT = 400000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [aps_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [aps_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          cmd_i = aps_pkg::CMD_POLL;
  logic [aps_pkg::TICK_W-1:0]    now_ticks_i = '0;
  logic [aps_pkg::SAMPLE_W-1:0]  adc_sample_i = '0;
  logic                          button_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          mute_level_o;
  logic                          reset_release_o;
  logic [1:0]                    amp_state_o;
  logic                          flash_start_o;
  logic [aps_pkg::SAMPLE_W-1:0]  peak_level_o;

  int unsigned                 send_idle_pct = 19;
  int unsigned                 recv_idle_pct = 87;
  bit                          hold_request = 1'b0;
  int                          hold_left = 0;
  int                          cycle_count = 0;
  aps_tb_pkg::amp_status_board board = new();

  amp_power_sequencer_brownout dut (.*);

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 60;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // result transfers
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_status('{mute_level_o, reset_release_o, amp_state_o,
                           flash_start_o, peak_level_o});
  end

  // offer one command, return at the falling edge after its transfer
  task automatic send_command(input logic cmd, input logic [aps_pkg::TICK_W-1:0] now,
                              input logic [aps_pkg::SAMPLE_W-1:0] sample,
                              input logic button);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    now_ticks_i  <= now;
    adc_sample_i <= sample;
    button_i     <= button;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_command(cmd, now, sample, button);
    @(negedge clk_i);
  endtask

  // wait for the block to go idle, then write all three registers
  task automatic apply_settings(input logic [aps_pkg::CFG_W-1:0] reset_wait,
                                input logic [aps_pkg::CFG_W-1:0] mute_wait,
                                input logic [aps_pkg::CFG_W-1:0] drop_limit);
    logic [aps_pkg::CFG_IDX_W-1:0] idx [3];
    logic [aps_pkg::CFG_W-1:0]     val [3];
    idx = '{aps_pkg::CFG_RESET_WAIT, aps_pkg::CFG_MUTE_WAIT, aps_pkg::CFG_DROP_LIMIT};
    val = '{reset_wait, mute_wait, drop_limit};
    in_valid_i <= 1'b0;
    while (board.pending_count() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      board.write_register(idx[i], val[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // pick a setting for the next block of random traffic
  task automatic random_settings();
    int unsigned rw;
    case ($urandom_range(0, 4))
      0: apply_settings(16'($urandom_range(0, 80)), 16'($urandom_range(0, 160)),
                        16'($urandom_range(0, 40)));
      1: begin
        // unmute wait below the reset wait
        rw = $urandom_range(50, 150);
        apply_settings(16'(rw), 16'($urandom_range(0, rw - 1)),
                       16'($urandom_range(0, 20)));
      end
      2: apply_settings('0, '0, '0);
      3: apply_settings('1, '1, '1);
      default: apply_settings(16'($urandom), 16'($urandom), 16'($urandom));
    endcase
  endtask

  // power-up sessions with random content plus some noise
  task automatic run_block(input int n_items);
    logic [aps_pkg::TICK_W-1:0] tick;
    int                         level;
    int                         v;
    int unsigned                roll;
    tick  = 16'($urandom);
    level = $urandom_range(0, 1023);
    send_command(aps_pkg::CMD_RESTART, tick, 10'($urandom), 1'($urandom_range(0, 1)));
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      // tick advance: mostly short, sometimes long, sometimes anywhere
      if (roll < 70) tick = 16'(tick + $urandom_range(0, 20));
      else if (roll < 90) tick = 16'(tick + $urandom_range(0, 600));
      else tick = 16'(tick + $urandom);
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        send_command(1'($urandom_range(0, 1)), 16'($urandom), 10'($urandom),
                     1'($urandom_range(0, 1)));
      end else if (roll < 16) begin
        send_command(aps_pkg::CMD_RESTART, tick, 10'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          v = level + int'($urandom_range(0, 12)) - 6;
        end else if (roll < 85) begin
          v = level - int'($urandom_range(10, 400));
        end else if (roll < 92) begin
          level = $urandom_range(0, 1023);
          v = level;
        end else begin
          v = $urandom_range(0, 1023);
        end
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        send_command(aps_pkg::CMD_POLL, tick, 10'(v), $urandom_range(0, 99) < 20);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default settings: walk the sequence and trip the guard
    send_command(aps_pkg::CMD_POLL, 16'd0, 10'd0, 1'b1);
    send_command(aps_pkg::CMD_POLL, 16'd299, 10'd1023, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'd300, 10'd512, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'd499, 10'd512, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'd500, 10'd1023, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'd501, 10'd1013, 1'b1);
    send_command(aps_pkg::CMD_POLL, 16'd502, 10'd1012, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'd503, 10'd0, 1'b0);
    // button in down state, together with a decay step
    send_command(aps_pkg::CMD_POLL, 16'h8000, 10'd7, 1'b1);
    // restart near the wrap, then both waits pass in one poll
    send_command(aps_pkg::CMD_RESTART, 16'hFF00, 10'd1023, 1'b1);
    send_command(aps_pkg::CMD_POLL, 16'h00FF, 10'd6, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'h4000, 10'd0, 1'b0);

    // unmute wait shorter than reset wait, zero drop allowed
    apply_settings(16'd100, 16'd20, 16'd0);
    send_command(aps_pkg::CMD_RESTART, 16'd0, 10'd0, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'd50, 10'd3, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'd100, 10'd4, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'd101, 10'd3, 1'b0);

    // longest waits and widest drop, peak held at zero across a decay
    apply_settings(16'hFFFF, 16'hFFFF, 16'd1023);
    send_command(aps_pkg::CMD_POLL, 16'h4000, 10'd0, 1'b1);
    send_command(aps_pkg::CMD_POLL, 16'h8000, 10'd0, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'h3FFF, 10'd1023, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'h3FFF, 10'd0, 1'b0);

    // no waits, upper data bits on the drop register
    apply_settings(16'd0, 16'd0, 16'hFFFF);
    send_command(aps_pkg::CMD_RESTART, 16'hFFFF, 10'd0, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'hFFFF, 10'd0, 1'b0);
    send_command(aps_pkg::CMD_POLL, 16'h1234, 10'd1, 1'b1);

    // random traffic across three idling regimes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 19; recv_idle_pct = 87; end
        1: begin send_idle_pct = 87; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        random_settings();
        if (blk == 0 && phase != 1) hold_request = 1'b1;
        run_block(115);
      end
    end

    // drain and settle
    in_valid_i <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
